FILE: design/sss_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sss_pkg: shared types and constants for the small set store
// Opcodes, status codes, field widths and the controller/datapath command.
// ---------------------------------------------------------------------------
package sss_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int VAL_W   = 32;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;
  localparam int OUT_W   = 8;   // was_member + status + count, exactly one byte

  // opcode 3 is unused and behaves as a query
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOCHANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture input word, register compare vector
    logic exec;   // apply update, load result register
  } sss_cmd_t;

endpackage

FILE: design/sss_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sss_ctrl: sequencing for the small set store
// Two-state controller: take a word, then execute it once the result
// register can accept. Owns the result valid flag.
// ---------------------------------------------------------------------------
module sss_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output sss_pkg::sss_cmd_t cmd
);
  import sss_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_vld_r, out_vld_nxt;

  always_comb begin
    cmd.load = (state_r == S_IDLE) && in_tvalid;
    cmd.exec = (state_r == S_EXEC) && (!out_vld_r || out_tready);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.exec) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (cmd.exec) out_vld_nxt = 1'b1;
    else if (out_tready) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;

  // a new result must never overwrite one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready) |-> !cmd.exec)
    else $error("result register overwritten while stalled");

endmodule

FILE: design/sss_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sss_dp: entry store, match compare and update logic
// Row of DEPTH registers with a per-entry comparator. Removal closes the
// gap by shifting every entry above the hit down by one in a single update.
// ---------------------------------------------------------------------------
module sss_dp #(
  parameter int DEPTH = sss_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sss_pkg::sss_cmd_t          cmd,
  input  logic [sss_pkg::OP_W-1:0]   in_opcode,
  input  logic [sss_pkg::VAL_W-1:0]  in_value,
  output logic                       res_was_member,
  output logic [sss_pkg::STAT_W-1:0] res_status,
  output logic [sss_pkg::COUNT_W-1:0] res_count
);
  import sss_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [VAL_W-1:0]  entries_r [DEPTH];
  logic [VAL_W-1:0]  entries_nxt [DEPTH];
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [OP_W-1:0]   op_r;
  logic [VAL_W-1:0]  val_r;
  logic [DEPTH-1:0]  match_r, match_nxt;

  logic              present;
  logic              full;
  logic [IW-1:0]     pos;
  logic              res_mem_r;
  logic [STAT_W-1:0] res_stat_r, res_stat_nxt;
  logic [COUNT_W-1:0] res_cnt_r;

  // per-entry compare, only live entries can hit
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_nxt[i] = (CW'(i) < cnt_r) && (entries_r[i] == in_value);
    end
  end

  // values are distinct, so at most one hit: OR the indices together
  always_comb begin
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match_r[i]) pos = pos | IW'(i);
    end
  end

  assign present = |match_r;
  assign full    = (cnt_r == CW'(DEPTH));

  always_comb begin
    cnt_nxt      = cnt_r;
    res_stat_nxt = ST_DONE;
    for (int i = 0; i < DEPTH; i++) entries_nxt[i] = entries_r[i];
    case (op_r)
      OP_INSERT: begin
        if (present) begin
          res_stat_nxt = ST_NOCHANGE;
        end else if (full) begin
          res_stat_nxt = ST_FULL;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (CW'(i) == cnt_r) entries_nxt[i] = val_r;
          end
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      OP_REMOVE: begin
        if (!present) begin
          res_stat_nxt = ST_NOCHANGE;
        end else begin
          for (int i = 0; i + 1 < DEPTH; i++) begin
            if (IW'(i) >= pos) entries_nxt[i] = entries_r[i + 1];
          end
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      default: res_stat_nxt = ST_DONE;  // query, unused code too
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_opcode;
      val_r   <= in_value;
      match_r <= match_nxt;
    end
    if (cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) entries_r[i] <= entries_nxt[i];
      res_mem_r  <= present;
      res_stat_r <= res_stat_nxt;
      res_cnt_r  <= COUNT_W'(cnt_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.exec) begin
      cnt_r <= cnt_nxt;
    end
  end

  assign res_was_member = res_mem_r;
  assign res_status     = res_stat_r;
  assign res_count      = res_cnt_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("element count beyond store depth");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && res_stat_nxt == ST_FULL) |-> full)
    else $error("full status with free entries");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && op_r == OP_REMOVE && present) |=> cnt_r == $past(cnt_r) - CW'(1))
    else $error("remove of a member did not shrink the count");

endmodule

FILE: design/small_set_store.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// small_set_store: bounded set of distinct 32-bit values
// Insert / remove / query against a small register store with a count.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one word per operation. in_tuser carries the
//   opcode (insert, remove, query; the unused code acts as a query),
//   in_tdata the 32-bit value.
//   Result channel (out_*): exactly one word per input word, in order:
//   was_member, status (done / no change / full) and the count afterwards.
//   Timing: a word is accepted, compared against all live entries in the
//   accept cycle, and applied in the execute state, when the result
//   register loads and out_tvalid rises. A new word is not accepted until
//   the current one has been applied. Removal shifts the tail of the store
//   down in a single update.
//   Stall: the result register holds while out_tready is low; the next
//   input word is still accepted and waits in its compare stage until
//   the result register frees up.
//   Reset: rst_n (synchronous, active low) empties the set and drops any
//   pending result. Entry contents are not cleared; only live entries
//   are ever compared.
// ---------------------------------------------------------------------------
module small_set_store #(
  parameter int DEPTH = sss_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [0] was_member, [2:1] status, [7:3] count
);
  import sss_pkg::*;

  sss_cmd_t           cmd;
  logic               res_was_member;
  logic [STAT_W-1:0]  res_status;
  logic [COUNT_W-1:0] res_count;

  sss_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  sss_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_opcode      (in_tuser),
    .in_value       (in_tdata),
    .res_was_member (res_was_member),
    .res_status     (res_status),
    .res_count      (res_count)
  );

  // pack result word, first field in the low bits
  assign out_tdata = {res_count, res_status, res_was_member};

endmodule
